/* rtl/ssmk_pkg.sv */
package ssmk_pkg;

    localparam int unsigned NUM_DIGITS     = 4;
    localparam int unsigned NUM_KEYS       = 4;
    localparam int unsigned HOLD_WIDTH_DEF = 16;
    localparam int unsigned SEG_W          = 8;
    localparam int unsigned LONG_W         = 16;
    localparam int unsigned RPT_W          = 8;
    localparam int unsigned PHASE_W        = $clog2(NUM_DIGITS + 1);

    localparam logic [SEG_W-1:0]   SEG_BLANK    = 8'hFF;
    localparam logic [LONG_W-1:0]  LONG_RESET   = 16'd100;
    localparam logic [RPT_W-1:0]   RPT_RESET    = 8'd20;
    localparam logic [PHASE_W-1:0] SCAN_PHASE   = PHASE_W'(NUM_DIGITS);

    typedef enum logic {
        REG_LONG_PRESS = 1'b0,
        REG_REPEAT_INT = 1'b1
    } t_reg_idx;

    typedef logic [NUM_DIGITS-1:0][SEG_W-1:0] t_pats;

    typedef struct packed {
        logic [NUM_DIGITS-1:0] sel;
        logic [SEG_W-1:0]      seg;
        logic                  oe;
        logic                  scan;
    } t_disp;

    typedef struct packed {
        logic [NUM_KEYS-1:0] status;
        logic [NUM_KEYS-1:0] push;
        logic [NUM_KEYS-1:0] rls;
        logic [NUM_KEYS-1:0] click;
        logic [NUM_KEYS-1:0] lng;
        logic [NUM_KEYS-1:0] rpt;
    } t_keys;

endpackage

/* rtl/ssmk_disp.sv */
module ssmk_disp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  ssmk_pkg::t_pats i_pats,
    output ssmk_pkg::t_disp o_disp
);
    import ssmk_pkg::*;

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic [PHASE_W-1:0] eff_phase;
    logic               all_blank;

    always_comb begin
        all_blank = 1'b1;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (i_pats[d] != SEG_BLANK) begin
                all_blank = 1'b0;
            end
        end
    end

    always_comb begin
        eff_phase = (all_blank || r_phase > SCAN_PHASE) ? SCAN_PHASE : r_phase;
        o_disp.sel  = '0;
        o_disp.seg  = SEG_BLANK;
        o_disp.oe   = 1'b0;
        o_disp.scan = 1'b1;
        n_phase     = '0;
        if (eff_phase < SCAN_PHASE) begin
            o_disp.sel[eff_phase[$clog2(NUM_DIGITS > 1 ? NUM_DIGITS : 2)-1:0]] = 1'b1;
            o_disp.seg  = i_pats[eff_phase[$clog2(NUM_DIGITS > 1 ? NUM_DIGITS : 2)-1:0]];
            o_disp.oe   = 1'b1;
            o_disp.scan = 1'b0;
            n_phase     = eff_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

endmodule

/* rtl/ssmk_keys.sv */
module ssmk_keys #(
    parameter int unsigned HOLD_WIDTH = ssmk_pkg::HOLD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic                            i_scan,
    input  logic                            i_clear,
    input  logic [ssmk_pkg::NUM_KEYS-1:0]   i_sample,
    input  logic [ssmk_pkg::NUM_KEYS-1:0]   i_push_ack,
    input  logic [ssmk_pkg::NUM_KEYS-1:0]   i_release_ack,
    input  logic [ssmk_pkg::LONG_W-1:0]     i_long_press,
    input  logic [ssmk_pkg::RPT_W-1:0]      i_repeat_int,
    output ssmk_pkg::t_keys                 o_keys
);
    import ssmk_pkg::*;

    localparam int unsigned CMP_W = (HOLD_WIDTH > LONG_W) ? HOLD_WIDTH : LONG_W;
    localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = '1;
    localparam t_keys KEYS_RST = t_keys'({{NUM_KEYS{1'b1}}, {(5 * NUM_KEYS){1'b0}}});

    t_keys                 r_keys;
    t_keys                 n_keys;
    logic [NUM_KEYS-1:0]   r_prev;
    logic [NUM_KEYS-1:0]   n_prev;
    logic [HOLD_WIDTH-1:0] r_hold [NUM_KEYS];
    logic [HOLD_WIDTH-1:0] n_hold [NUM_KEYS];
    logic [RPT_W-1:0]      r_rcnt [NUM_KEYS];
    logic [RPT_W-1:0]      n_rcnt [NUM_KEYS];

    always_comb begin
        logic [NUM_KEYS-1:0]   push_e;
        logic [NUM_KEYS-1:0]   rls_e;
        logic [CMP_W-1:0]      long_x;
        logic [CMP_W-1:0]      hold_x;
        logic [HOLD_WIDTH-1:0] h;
        logic [RPT_W-1:0]      rc;

        n_keys = r_keys;
        n_prev = r_prev;
        for (int k = 0; k < NUM_KEYS; k++) begin
            n_hold[k] = r_hold[k];
            n_rcnt[k] = r_rcnt[k];
        end
        long_x = CMP_W'(i_long_press);
        hold_x = '0;
        h      = '0;
        rc     = '0;
        push_e = '0;
        rls_e  = '0;

        if (i_clear) begin
            n_keys.status = '1;
            n_prev        = '1;
            n_keys.click  = '0;
            n_keys.lng    = '0;
            n_keys.rpt    = '0;
        end
        n_keys.push = n_keys.push & ~i_push_ack;
        n_keys.rls  = n_keys.rls & ~i_release_ack;

        if (i_scan) begin
            push_e        = ~i_sample & n_prev;
            rls_e         = i_sample & ~n_prev;
            n_keys.status = i_sample;
            n_prev        = i_sample;
            n_keys.push   = n_keys.push | push_e;
            n_keys.rls    = n_keys.rls | rls_e;
            for (int k = 0; k < NUM_KEYS; k++) begin
                hold_x = CMP_W'(r_hold[k]);
                if (rls_e[k] && hold_x < long_x) begin
                    n_keys.click[k] = 1'b1;
                end
                if (!i_sample[k]) begin
                    h = (r_hold[k] < HOLD_MAX) ? r_hold[k] + 1'b1 : r_hold[k];
                    n_hold[k] = h;
                    hold_x = CMP_W'(h);
                    if (hold_x == long_x) begin
                        n_keys.lng[k] = 1'b1;
                        n_rcnt[k]     = '0;
                    end else if (hold_x > long_x) begin
                        rc = r_rcnt[k] + 1'b1;
                        if (rc >= i_repeat_int) begin
                            rc            = '0;
                            n_keys.rpt[k] = 1'b1;
                        end
                        n_rcnt[k] = rc;
                    end
                end else begin
                    n_hold[k] = '0;
                    n_rcnt[k] = '0;
                end
            end
        end
    end

    assign o_keys = n_keys;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= KEYS_RST;
            r_prev <= '1;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_hold[k] <= '0;
                r_rcnt[k] <= '0;
            end
        end else if (i_step) begin
            r_keys <= n_keys;
            r_prev <= n_prev;
            for (int k = 0; k < NUM_KEYS; k++) begin
                r_hold[k] <= n_hold[k];
                r_rcnt[k] <= n_rcnt[k];
            end
        end
    end

endmodule

/* rtl/seven_segment_mux_key_scanner.sv */
// Multiplexed seven-segment display driver with four-key scanner.
// Input channel (i_in_valid / o_in_stall): one request per 1 ms tick, carrying
// the key levels, four digit patterns, clear-all, push/release acks and a
// wait load. Output channel (o_out_valid / i_out_stall): one result per
// request with the digit select, segment drive and enable, key status, the
// five sticky flag sets, wait busy and the tick count.
// The block cycles four digit phases and one key scan phase; if all four
// patterns are blank every tick scans keys.
// A request passes an input register, then one pass of logic that updates the
// state and loads the output register. Throughput is one request per clock
// while the receiver does not stall; the input and output registers decouple
// the two sides. When the receiver stalls, the output holds and the input
// register fills if empty; o_in_stall then stays high until the output drains.
// Reset (synchronous, i_rst_n low) clears phase, hold and repeat counts, flags,
// wait and tick counters, sets key status to all released and restores the
// long press threshold to 100 scans and the repeat interval to 20 scans.
// Config registers over APB: 0x0 long press scans, 0x4 repeat interval.
module seven_segment_mux_key_scanner #(
    parameter int unsigned HOLD_WIDTH = ssmk_pkg::HOLD_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_key_sample,
    input  logic [7:0]  i_digit0_pattern,
    input  logic [7:0]  i_digit1_pattern,
    input  logic [7:0]  i_digit2_pattern,
    input  logic [7:0]  i_digit3_pattern,
    input  logic        i_clear_all,
    input  logic [3:0]  i_push_ack,
    input  logic [3:0]  i_release_ack,
    input  logic        i_wait_load,
    input  logic [15:0] i_wait_value,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_digit_select,
    output logic [7:0]  o_segment_drive,
    output logic        o_segment_output_enable,
    output logic [3:0]  o_key_status,
    output logic [3:0]  o_push_flags,
    output logic [3:0]  o_release_flags,
    output logic [3:0]  o_click_flags,
    output logic [3:0]  o_long_flags,
    output logic [3:0]  o_repeat_flags,
    output logic        o_wait_busy,
    output logic [31:0] o_tick_count,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ssmk_pkg::*;

    // input register
    logic                r_in_valid;
    logic [3:0]          r_keys_in;
    t_pats               r_pats;
    logic                r_clear;
    logic [3:0]          r_pack;
    logic [3:0]          r_rack;
    logic                r_wload;
    logic [15:0]         r_wval;

    // config
    logic [LONG_W-1:0]   r_long_press;
    logic [RPT_W-1:0]    r_repeat_int;
    t_reg_idx            reg_sel;

    // counters
    logic [15:0]         r_wait;
    logic [15:0]         n_wait;
    logic [31:0]         r_ticks;
    logic [31:0]         n_ticks;

    // output register
    logic                r_out_valid;
    t_disp               r_disp;
    t_keys               r_keys_out;
    logic                r_busy;
    logic [31:0]         r_tick_out;

    logic                accept;
    logic                advance;
    t_disp               disp;
    t_keys               keys;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_keys_in <= i_key_sample;
            r_pats    <= {i_digit3_pattern, i_digit2_pattern,
                          i_digit1_pattern, i_digit0_pattern};
            r_clear   <= i_clear_all;
            r_pack    <= i_push_ack;
            r_rack    <= i_release_ack;
            r_wload   <= i_wait_load;
            r_wval    <= i_wait_value;
        end
    end

    // APB registers
    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (reg_sel)
            REG_LONG_PRESS: prdata = 32'(r_long_press);
            REG_REPEAT_INT: prdata = 32'(r_repeat_int);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press <= LONG_RESET;
            r_repeat_int <= RPT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_sel)
                REG_LONG_PRESS: r_long_press <= pwdata[LONG_W-1:0];
                REG_REPEAT_INT: r_repeat_int <= pwdata[RPT_W-1:0];
                default: ;
            endcase
        end
    end

    ssmk_disp u_disp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_pats  (r_pats),
        .o_disp  (disp)
    );

    ssmk_keys #(
        .HOLD_WIDTH (HOLD_WIDTH)
    ) u_keys (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_scan        (disp.scan),
        .i_clear       (r_clear),
        .i_sample      (r_keys_in),
        .i_push_ack    (r_pack),
        .i_release_ack (r_rack),
        .i_long_press  (r_long_press),
        .i_repeat_int  (r_repeat_int),
        .o_keys        (keys)
    );

    // wait countdown: load first, then one decrement in the same tick
    always_comb begin
        n_wait  = r_wload ? r_wval : r_wait;
        n_wait  = (n_wait != '0) ? n_wait - 1'b1 : n_wait;
        n_ticks = r_ticks + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait  <= '0;
            r_ticks <= '0;
        end else if (advance) begin
            r_wait  <= n_wait;
            r_ticks <= n_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_disp     <= disp;
            r_keys_out <= keys;
            r_busy     <= (n_wait != '0);
            r_tick_out <= n_ticks;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_digit_select          = r_disp.sel;
    assign o_segment_drive         = r_disp.seg;
    assign o_segment_output_enable = r_disp.oe;
    assign o_key_status            = r_keys_out.status;
    assign o_push_flags            = r_keys_out.push;
    assign o_release_flags         = r_keys_out.rls;
    assign o_click_flags           = r_keys_out.click;
    assign o_long_flags            = r_keys_out.lng;
    assign o_repeat_flags          = r_keys_out.rpt;
    assign o_wait_busy             = r_busy;
    assign o_tick_count            = r_tick_out;

endmodule
